FILE: rtl/core/otq_pkg.sv
`default_nettype none
package otq_pkg;
	localparam int unsigned SLOT_W = 5;
	localparam int unsigned TIME_W = 64;
	localparam int unsigned IVAL_W = 32;
	localparam int unsigned STAT_W = 2;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_CANCEL = 2'd1,
		CMD_EXPIRE = 2'd2,
		CMD_FINISH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REJECT   = 2'd1,
		ST_NOTHING  = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_EMIT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]          command;
		logic [SLOT_W-1:0]   slot;
		logic [TIME_W-1:0]   expiry_time;
		logic [IVAL_W-1:0]   interval_us;
		logic [TIME_W-1:0]   now_time;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic [SLOT_W-1:0]   expired_slot;
		logic                earliest_changed;
		logic                next_valid;
		logic [TIME_W-1:0]   next_expiry;
		logic                last;
	} out_item_t;
endpackage
`default_nettype wire

FILE: rtl/core/otq_in_if.sv
`default_nettype none
interface otq_in_if;
	logic                valid;
	logic                ready;
	otq_pkg::in_item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/otq_out_if.sv
`default_nettype none
interface otq_out_if;
	logic                valid;
	logic                ready;
	otq_pkg::out_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/otq_ram.sv
`default_nettype none
module otq_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/ordered_timer_queue.sv
// ordered timer queue
// in: one transfer per command (add, cancel, expire, finish); out: result transfers,
// the final one of each command carries last.
// every command sweeps the slot table once through the expiry and interval rams,
// one slot per cycle, to find the earliest armed expiry, the due set and to rearm.
// expire then runs one more sweep per emitted slot to pick the next in order.
// a command is swept in S_SCAN, settled in S_DECIDE and its result is presented in
// S_OUT; an expire with due slots gives no result from S_DECIDE and instead runs an
// S_EMIT sweep and an S_OUT result for each due slot. the next command is taken once
// the sequencer is back in S_IDLE and the output register is empty; one command is in
// flight at a time.
// results sit in an output register; while the receiver stalls the sequencer
// waits and the next command is not taken until the last result transfers.
// reset clears the armed, pending and cancel bits and the callback window; the
// rams hold no reset value; slot data is used only after an add has written it.
`default_nettype none
module ordered_timer_queue #(
	parameter int unsigned SLOTS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	otq_in_if.sink   in_ch,
	otq_out_if.source out_ch
);
	localparam int unsigned USED = (SLOTS < 32) ? SLOTS : 32;
	localparam int unsigned AW = (USED > 1) ? $clog2(USED) : 1;
	localparam int unsigned CW = $clog2(USED + 1);
	localparam logic [CW-1:0] LAST_IDX = CW'(USED - 1);

	otq_pkg::state_t state_q, state_d;
	otq_pkg::in_item_t cmd_q;

	logic [USED-1:0] armed_q, pend_q, mark_q, due_q;
	logic            incb_q;

	logic [CW-1:0]   idx_q;
	logic            rd_vld_s1;
	logic [AW-1:0]   rd_idx_s1;
	logic            rd_last_s1;

	logic                         best_vld_q;
	logic [otq_pkg::TIME_W-1:0]   best_q;
	logic [AW-1:0]                pick_q;

	otq_pkg::out_item_t out_q;
	logic               out_vld_q;

	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [otq_pkg::TIME_W-1:0]   exp_wdata, exp_rdata;
	logic [otq_pkg::IVAL_W-1:0]   iv_wdata, iv_rdata;
	logic [AW-1:0]                ram_raddr;

	otq_ram #(.WIDTH(otq_pkg::TIME_W), .DEPTH(1 << AW)) u_exp (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(exp_wdata),
		.raddr(ram_raddr), .rdata(exp_rdata)
	);
	otq_ram #(.WIDTH(otq_pkg::IVAL_W), .DEPTH(1 << AW)) u_iv (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(iv_wdata),
		.raddr(ram_raddr), .rdata(iv_rdata)
	);

	logic in_xfer, out_xfer;
	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_xfer = out_ch.valid && out_ch.ready;
	assign in_ch.ready = (state_q == otq_pkg::S_IDLE) && !out_vld_q;
	assign out_ch.valid = out_vld_q;
	assign out_ch.data  = out_q;
	assign ram_raddr = idx_q[AW-1:0];

	logic [AW-1:0] cslot;
	logic          slot_ok;
	assign cslot   = cmd_q.slot[AW-1:0];
	assign slot_ok = {27'd0, cmd_q.slot} < 32'(USED);

	logic          add_busy;
	assign add_busy = !slot_ok || armed_q[cslot] || pend_q[cslot];

	otq_pkg::cmd_t ccmd;
	assign ccmd = otq_pkg::cmd_t'(cmd_q.command);

	// per-slot work during a sweep
	logic                       is_armed, is_due, do_rearm, take_best;
	logic [otq_pkg::TIME_W:0]   rsum;
	logic [otq_pkg::TIME_W-1:0] rearm_val;
	logic [otq_pkg::TIME_W-1:0] cand;
	logic                       cand_vld;

	always_comb begin
		rsum = {1'b0, cmd_q.now_time} + {33'd0, iv_rdata};
		rearm_val = rsum[otq_pkg::TIME_W] ? '1 : rsum[otq_pkg::TIME_W-1:0];
		is_armed = armed_q[rd_idx_s1];
		is_due = 1'b0;
		do_rearm = 1'b0;
		cand = exp_rdata;
		cand_vld = 1'b0;
		unique case (ccmd)
			otq_pkg::CMD_EXPIRE: begin
				if (state_q == otq_pkg::S_SCAN) begin
					is_due = is_armed && (exp_rdata <= cmd_q.now_time);
					cand_vld = is_armed && !is_due;
				end else begin
					cand_vld = due_q[rd_idx_s1];
				end
			end
			otq_pkg::CMD_FINISH: begin
				do_rearm = pend_q[rd_idx_s1] && (iv_rdata != '0) && !mark_q[rd_idx_s1];
				cand_vld = is_armed || do_rearm;
				if (do_rearm) begin
					cand = rearm_val;
				end
			end
			default: begin
				cand_vld = is_armed;
				if (ccmd == otq_pkg::CMD_CANCEL && slot_ok && cslot == rd_idx_s1) begin
					cand_vld = 1'b0;
				end
			end
		endcase
		take_best = rd_vld_s1 && cand_vld && (!best_vld_q || cand < best_q);
	end

	// pick including the slot read in this cycle
	logic [AW-1:0] pick_fin;
	assign pick_fin = take_best ? rd_idx_s1 : pick_q;

	// add writes on entry; finish writes rearmed expiries during the sweep
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = rd_idx_s1;
		exp_wdata = rearm_val;
		iv_wdata = iv_rdata;
		if (in_xfer && otq_pkg::cmd_t'(in_ch.data.command) == otq_pkg::CMD_ADD
				&& {27'd0, in_ch.data.slot} < 32'(USED)
				&& !(armed_q[in_ch.data.slot[AW-1:0]] || pend_q[in_ch.data.slot[AW-1:0]])) begin
			ram_we = 1'b1;
			ram_waddr = in_ch.data.slot[AW-1:0];
			exp_wdata = in_ch.data.expiry_time;
			iv_wdata = in_ch.data.interval_us;
		end else if (rd_vld_s1 && state_q == otq_pkg::S_SCAN && do_rearm) begin
			ram_we = 1'b1;
		end
	end

	logic sweep_done;
	assign sweep_done = rd_vld_s1 && rd_last_s1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			otq_pkg::S_IDLE:   if (in_xfer) state_d = otq_pkg::S_SCAN;
			otq_pkg::S_SCAN:   if (sweep_done) state_d = otq_pkg::S_DECIDE;
			otq_pkg::S_DECIDE: state_d = otq_pkg::S_OUT;
			otq_pkg::S_EMIT:   if (sweep_done) state_d = otq_pkg::S_OUT;
			otq_pkg::S_OUT: begin
				if (!out_vld_q) begin
					if (ccmd == otq_pkg::CMD_EXPIRE && due_q != '0) begin
						state_d = otq_pkg::S_EMIT;
					end else begin
						state_d = otq_pkg::S_IDLE;
					end
				end
			end
			default: state_d = otq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= otq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic sweeping, start_sweep;
	assign sweeping = (state_q == otq_pkg::S_SCAN || state_q == otq_pkg::S_EMIT)
		&& idx_q <= LAST_IDX;
	assign start_sweep = in_xfer || (state_q == otq_pkg::S_OUT && state_d == otq_pkg::S_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			rd_last_s1 <= 1'b0;
			best_vld_q <= 1'b0;
			armed_q <= '0;
			pend_q <= '0;
			mark_q <= '0;
			due_q <= '0;
			incb_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= sweeping;
			rd_idx_s1 <= idx_q[AW-1:0];
			rd_last_s1 <= idx_q == LAST_IDX;
			if (start_sweep) begin
				idx_q <= '0;
				best_vld_q <= 1'b0;
			end else if (sweeping) begin
				idx_q <= idx_q + 1'b1;
			end
			if (take_best) begin
				best_vld_q <= 1'b1;
			end
			if (out_xfer) begin
				out_vld_q <= 1'b0;
			end
			if (rd_vld_s1 && state_q == otq_pkg::S_SCAN) begin
				if (is_due) begin
					armed_q[rd_idx_s1] <= 1'b0;
					due_q[rd_idx_s1] <= 1'b1;
					pend_q[rd_idx_s1] <= 1'b1;
				end
				if (do_rearm) begin
					armed_q[rd_idx_s1] <= 1'b1;
				end
			end
			if (state_q == otq_pkg::S_DECIDE) begin
				out_vld_q <= !(ccmd == otq_pkg::CMD_EXPIRE && due_q != '0);
				unique case (ccmd)
					otq_pkg::CMD_ADD: begin
						if (!add_busy) begin
							armed_q[cslot] <= 1'b1;
						end
					end
					otq_pkg::CMD_CANCEL: begin
						if (slot_ok) begin
							if (armed_q[cslot]) begin
								armed_q[cslot] <= 1'b0;
							end else if (incb_q) begin
								mark_q[cslot] <= 1'b1;
							end
						end
					end
					otq_pkg::CMD_EXPIRE: begin
						if (!incb_q) begin
							mark_q <= '0;
						end
						incb_q <= 1'b1;
					end
					otq_pkg::CMD_FINISH: begin
						pend_q <= '0;
						mark_q <= '0;
						incb_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == otq_pkg::S_EMIT && sweep_done) begin
				due_q[pick_fin] <= 1'b0;
				out_vld_q <= 1'b1;
			end
		end
	end

	// best over the sweep; in expire scan it is the next armed minimum
	always_ff @(posedge clk) begin
		if (take_best) begin
			best_q <= cand;
			pick_q <= rd_idx_s1;
		end
		if (in_xfer) begin
			cmd_q <= in_ch.data;
		end
	end

	// next expiry for expire results: armed minimum from the first sweep
	logic [otq_pkg::TIME_W-1:0] nx_q;
	logic                       nxv_q;
	logic                       add_ok, add_first;
	assign add_ok    = ccmd == otq_pkg::CMD_ADD && !add_busy;
	assign add_first = !best_vld_q || cmd_q.expiry_time < best_q;

	always_ff @(posedge clk) begin
		if (state_q == otq_pkg::S_DECIDE) begin
			nx_q <= best_q;
			nxv_q <= best_vld_q;
			out_q.expired_slot <= '0;
			out_q.last <= 1'b1;
			out_q.earliest_changed <= add_ok && add_first;
			out_q.status <= (ccmd == otq_pkg::CMD_ADD && add_busy) ? otq_pkg::ST_REJECT
				: (ccmd == otq_pkg::CMD_EXPIRE) ? otq_pkg::ST_NOTHING : otq_pkg::ST_OK;
			out_q.next_valid <= best_vld_q || add_ok;
			out_q.next_expiry <= add_ok ? (add_first ? cmd_q.expiry_time : best_q)
				: (best_vld_q ? best_q : '0);
		end
		if (state_q == otq_pkg::S_EMIT && sweep_done) begin
			out_q.status <= otq_pkg::ST_OK;
			out_q.expired_slot <= otq_pkg::SLOT_W'(pick_fin);
			out_q.earliest_changed <= 1'b0;
			out_q.next_valid <= nxv_q;
			out_q.next_expiry <= nxv_q ? nx_q : '0;
			out_q.last <= $countones(due_q) == 1;
		end
	end

	property p_one_cmd;
		@(posedge clk) disable iff (!arst_n) in_xfer |=> !in_ch.ready;
	endproperty
	a_one_cmd: assert property (p_one_cmd) else $error("command taken while busy");

	property p_pend_armed;
		@(posedge clk) disable iff (!arst_n) (pend_q & armed_q & ~{USED{state_q == otq_pkg::S_SCAN}}) == '0
			|| ccmd == otq_pkg::CMD_FINISH;
	endproperty
	a_pend_armed: assert property (p_pend_armed) else $error("slot armed and pending");

	property p_emit_due;
		@(posedge clk) disable iff (!arst_n)
			(state_q == otq_pkg::S_EMIT && sweep_done) |-> due_q[pick_fin];
	endproperty
	a_emit_due: assert property (p_emit_due) else $error("emitted slot not due");
endmodule
`default_nettype wire
